// File: sv/frt_pkg.sv
package frt_pkg;

   localparam logic [3:0] ST_NEW     = 4'd0;
   localparam logic [3:0] ST_ADDED   = 4'd1;
   localparam logic [3:0] ST_DUP     = 4'd2;
   localparam logic [3:0] ST_REPEAT  = 4'd3;
   localparam logic [3:0] ST_BIG     = 4'd4;
   localparam logic [3:0] ST_FULL    = 4'd5;
   localparam logic [3:0] ST_POOL    = 4'd6;
   localparam logic [3:0] ST_CLOSING = 4'd7;
   localparam logic [3:0] ST_SWEEP   = 4'd8;

   localparam logic [1:0] REG_TIMEOUT  = 2'd0;
   localparam logic [1:0] REG_HOLD     = 2'd1;
   localparam logic [1:0] REG_NO_OVERR = 2'd2;

   localparam logic [31:0] TIMEOUT_RESET = 32'd3000000;
   localparam logic [31:0] HOLD_RESET    = 32'd250;
   localparam logic [31:0] HALF_RANGE    = 32'h7FFF_FFFF;

   localparam int REQ_DATA_W = 216;
   localparam int RSP_DATA_W = 16;
   localparam int IV_W       = 22;

   // Keeps the low len bytes of a right-aligned address; eight or more keeps all.
   function automatic logic [63:0] addr_mask(input logic [3:0] len);
      logic [63:0] m;
      m = '1;
      if (len < 4'd8) begin
         m = (64'd1 << {len[2:0], 3'b000}) - 64'd1;
      end
      return m;
   endfunction

endpackage

// File: sv/frt_ram.sv
module frt_ram #(
   parameter int WIDTH = 22,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// File: sv/fragment_reassembly_tracker.sv
// Fragment reassembly tracker. Each request transaction carries one fragment
// descriptor (or, with tuser set, a timeout sweep) and yields exactly one response
// transaction with status, slot, complete, evicted and expired count. The block
// works on one item at a time and drops req_tready until the result is registered.
// A fragment's handling is dominated by the scan of the interval pool, one entry
// per cycle through the read port of the pool memory. A fragment that causes an
// overlap restart runs the whole sequence twice. Slot size, arrival time, received
// count and the interval valid bits sit in flip-flops and are cleared by reset at
// once; the other slot fields are not reset.
module fragment_reassembly_tracker #(
   parameter int SLOTS     = 4,
   parameter int INTERVALS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // Fields from bit 0: src_addr, src_len, dst_addr, dst_len, dgram_size,
   // tag, frag_offset, frag_len, now.
   input  logic [frt_pkg::REQ_DATA_W-1:0]   req_tdata,
   // Fields from bit 0: func.
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // Fields from bit 0: status, slot, complete, evicted, expired_count.
   output logic [frt_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [3:0]                       csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);

   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int IW = $clog2(INTERVALS);

   typedef enum logic [3:0] {
      S_IDLE, S_SWEEP, S_MATCH, S_DECIDE, S_RANGE, S_SCAN, S_SCAN_LAST, S_POOL,
      S_COMPLETE, S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic [31:0] timeout_ff, timeout_in, hold_ff, hold_in;
   logic        no_ov_ff, no_ov_in;

   logic        func_ff, func_in;
   logic [63:0] src_ff, src_in, dst_ff, dst_in;
   logic [7:0]  lens_ff, lens_in;
   logic [10:0] size_ff, size_in, off_ff, off_in, last_ff, last_in;
   logic [15:0] tag_ff, tag_in;
   logic [7:0]  len_ff, len_in;
   logic [31:0] now_ff, now_in;

   logic [10:0] sl_size_ff [SLOTS];
   logic [10:0] sl_size_in [SLOTS];
   logic [15:0] sl_tag_ff [SLOTS];
   logic [15:0] sl_tag_in [SLOTS];
   logic [63:0] sl_src_ff [SLOTS];
   logic [63:0] sl_src_in [SLOTS];
   logic [63:0] sl_dst_ff [SLOTS];
   logic [63:0] sl_dst_in [SLOTS];
   logic [7:0]  sl_lens_ff [SLOTS];
   logic [7:0]  sl_lens_in [SLOTS];
   logic [31:0] sl_arr_ff [SLOTS];
   logic [31:0] sl_arr_in [SLOTS];
   logic [11:0] sl_recv_ff [SLOTS];
   logic [11:0] sl_recv_in [SLOTS];

   logic [INTERVALS-1:0] iv_valid_ff, iv_valid_in, own_mask;
   logic [SW-1:0]        iv_owner_ff [INTERVALS];
   logic [SW-1:0]        iv_owner_in [INTERVALS];

   logic [SW-1:0] idx_ff, idx_in, found_ff, found_in, free_ff, free_in;
   logic [SW-1:0] old_ff, old_in, cur_ff, cur_in, slot_ff, slot_in;
   logic          found_vld_ff, found_vld_in, free_vld_ff, free_vld_in;
   logic          old_vld_ff, old_vld_in, pass2_ff, pass2_in;
   logic [3:0]    st_pass_ff, st_pass_in, st_ff, st_in;
   logic          evicted_ff, evicted_in, complete_ff, complete_in;
   logic [2:0]    expired_ff, expired_in;
   logic [IW-1:0] k_ff, k_in, kd_ff, kd_in, ffr_ff, ffr_in;
   logic          chk_ff, chk_in, rep_ff, rep_in, dup_ff, dup_in;
   logic          ffr_vld_ff, ffr_vld_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [frt_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic          free_en, clr_en, ret_en, match, hit, ovl, same, ram_we;
   logic [SW-1:0] free_sel;
   logic [3:0]    ret_code;
   logic [10:0]   r_start, r_end;
   logic [11:0]   frag_end;
   logic [frt_pkg::IV_W-1:0] ram_rdata;
   logic          csr_wr;

   frt_ram #(.WIDTH(frt_pkg::IV_W), .DEPTH(INTERVALS)) u_pool (
      .clock (clock),
      .we    (ram_we),
      .waddr (ffr_ff),
      .wdata ({off_ff, last_ff}),
      .raddr (k_ff),
      .rdata (ram_rdata)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign r_start    = ram_rdata[21:11];
   assign r_end      = ram_rdata[10:0];
   assign frag_end   = {1'b0, off_ff} + {4'd0, len_ff};

   always_comb begin
      csr_prdata = '0;
      unique case (csr_paddr[3:2])
         frt_pkg::REG_TIMEOUT:  csr_prdata = timeout_ff;
         frt_pkg::REG_HOLD:     csr_prdata = hold_ff;
         frt_pkg::REG_NO_OVERR: csr_prdata = {31'd0, no_ov_ff};
         default:               csr_prdata = '0;
      endcase
   end

   always_comb begin
      for (int k = 0; k < INTERVALS; k++) begin
         own_mask[k] = (iv_owner_ff[k] == free_sel);
      end
   end

   assign hit  = iv_valid_ff[kd_ff] && (iv_owner_ff[kd_ff] == cur_ff);
   assign ovl  = (r_start <= last_ff) && (off_ff <= r_end);
   assign same = (r_start == off_ff) && (r_end == last_ff);
   assign match = (sl_size_ff[idx_ff] != 11'd0) && (sl_size_ff[idx_ff] == size_ff) &&
                  (sl_tag_ff[idx_ff] == tag_ff) && (sl_lens_ff[idx_ff] == lens_ff) &&
                  (sl_src_ff[idx_ff] == src_ff) && (sl_dst_ff[idx_ff] == dst_ff);

   always_comb begin
      state_in = state_ff;
      timeout_in = timeout_ff;
      hold_in = hold_ff;
      no_ov_in = no_ov_ff;
      func_in = func_ff;
      src_in = src_ff;
      dst_in = dst_ff;
      lens_in = lens_ff;
      size_in = size_ff;
      off_in = off_ff;
      last_in = last_ff;
      tag_in = tag_ff;
      len_in = len_ff;
      now_in = now_ff;
      sl_size_in = sl_size_ff;
      sl_tag_in = sl_tag_ff;
      sl_src_in = sl_src_ff;
      sl_dst_in = sl_dst_ff;
      sl_lens_in = sl_lens_ff;
      sl_arr_in = sl_arr_ff;
      sl_recv_in = sl_recv_ff;
      iv_valid_in = iv_valid_ff;
      iv_owner_in = iv_owner_ff;
      idx_in = idx_ff;
      found_in = found_ff;
      free_in = free_ff;
      old_in = old_ff;
      cur_in = cur_ff;
      slot_in = slot_ff;
      found_vld_in = found_vld_ff;
      free_vld_in = free_vld_ff;
      old_vld_in = old_vld_ff;
      pass2_in = pass2_ff;
      st_pass_in = st_pass_ff;
      st_in = st_ff;
      evicted_in = evicted_ff;
      complete_in = complete_ff;
      expired_in = expired_ff;
      k_in = k_ff;
      kd_in = kd_ff;
      ffr_in = ffr_ff;
      chk_in = chk_ff;
      rep_in = rep_ff;
      dup_in = dup_ff;
      ffr_vld_in = ffr_vld_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      free_en = 1'b0;
      clr_en = 1'b0;
      free_sel = cur_ff;
      ret_en = 1'b0;
      ret_code = frt_pkg::ST_ADDED;
      ram_we = 1'b0;

      if (csr_wr) begin
         unique case (csr_paddr[3:2])
            frt_pkg::REG_TIMEOUT:  timeout_in = csr_pwdata;
            frt_pkg::REG_HOLD:     hold_in = csr_pwdata;
            frt_pkg::REG_NO_OVERR: no_ov_in = csr_pwdata[0];
            default: ;
         endcase
      end

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               func_in = req_tuser;
               src_in = req_tdata[63:0] & frt_pkg::addr_mask(req_tdata[67:64]);
               dst_in = req_tdata[131:68] & frt_pkg::addr_mask(req_tdata[135:132]);
               lens_in = {req_tdata[135:132], req_tdata[67:64]};
               size_in = req_tdata[146:136];
               tag_in = req_tdata[162:147];
               off_in = req_tdata[173:163];
               len_in = req_tdata[181:174];
               now_in = req_tdata[213:182];
               pass2_in = 1'b0;
               evicted_in = 1'b0;
               expired_in = '0;
               complete_in = 1'b0;
               slot_in = '0;
               idx_in = '0;
               state_in = S_SWEEP;
            end
         end
         S_SWEEP: begin
            if ((sl_size_ff[idx_ff] != 11'd0) &&
                ((now_ff - sl_arr_ff[idx_ff]) > timeout_ff)) begin
               free_en = 1'b1;
               free_sel = idx_ff;
               if (expired_ff != 3'd7) begin
                  expired_in = expired_ff + 3'd1;
               end
            end
            if (idx_ff == SW'(SLOTS - 1)) begin
               idx_in = '0;
               found_vld_in = 1'b0;
               free_vld_in = 1'b0;
               old_vld_in = 1'b0;
               if (func_ff) begin
                  st_in = frt_pkg::ST_SWEEP;
                  state_in = S_FINISH;
               end else begin
                  state_in = S_MATCH;
               end
            end else begin
               idx_in = idx_ff + SW'(1);
            end
         end
         S_MATCH: begin
            if (match) begin
               found_vld_in = 1'b1;
               found_in = idx_ff;
               state_in = S_DECIDE;
            end else begin
               if (!free_vld_ff && (sl_size_ff[idx_ff] == 11'd0)) begin
                  free_vld_in = 1'b1;
                  free_in = idx_ff;
               end
               if (!old_vld_ff || ((sl_arr_ff[old_ff] - sl_arr_ff[idx_ff]) <
                                   frt_pkg::HALF_RANGE)) begin
                  old_vld_in = 1'b1;
                  old_in = idx_ff;
               end
               if (idx_ff == SW'(SLOTS - 1)) begin
                  state_in = S_DECIDE;
               end else begin
                  idx_in = idx_ff + SW'(1);
               end
            end
         end
         S_DECIDE: begin
            if (found_vld_ff) begin
               cur_in = found_ff;
               slot_in = found_ff;
               if ((hold_ff != 32'd0) && (sl_recv_ff[found_ff] == 12'd0)) begin
                  ret_en = 1'b1;
                  ret_code = frt_pkg::ST_CLOSING;
               end else begin
                  sl_arr_in[found_ff] = now_ff;
                  st_pass_in = frt_pkg::ST_ADDED;
                  state_in = S_RANGE;
               end
            end else if (!free_vld_ff && no_ov_ff &&
                         ((now_ff - sl_arr_ff[old_ff]) <= timeout_ff)) begin
               slot_in = '0;
               ret_en = 1'b1;
               ret_code = frt_pkg::ST_FULL;
            end else begin
               // With no free slot the oldest one is evicted; its size is
               // overwritten below, so only its intervals need clearing.
               if (!free_vld_ff) begin
                  clr_en = 1'b1;
                  free_sel = old_ff;
                  evicted_in = 1'b1;
                  cur_in = old_ff;
                  slot_in = old_ff;
               end else begin
                  cur_in = free_ff;
                  slot_in = free_ff;
               end
               sl_size_in[cur_in] = size_ff;
               sl_arr_in[cur_in] = now_ff;
               sl_src_in[cur_in] = src_ff;
               sl_dst_in[cur_in] = dst_ff;
               sl_lens_in[cur_in] = lens_ff;
               sl_tag_in[cur_in] = tag_ff;
               sl_recv_in[cur_in] = '0;
               st_pass_in = frt_pkg::ST_NEW;
               state_in = S_RANGE;
            end
         end
         S_RANGE: begin
            if ((len_ff == 8'd0) || (frag_end > {1'b0, sl_size_ff[cur_ff]})) begin
               free_en = 1'b1;
               ret_en = 1'b1;
               ret_code = frt_pkg::ST_BIG;
            end else begin
               last_in = 11'(frag_end - 12'd1);
               k_in = '0;
               chk_in = 1'b0;
               rep_in = 1'b0;
               dup_in = 1'b0;
               ffr_vld_in = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN, S_SCAN_LAST: begin
            // Pool data is registered and arrives in the cycle after its address; kd_ff names it.
            if (chk_ff) begin
               if (hit) begin
                  if (ovl && !same) begin
                     rep_in = 1'b1;
                  end else if (r_start == off_ff) begin
                     dup_in = 1'b1;
                  end
               end
               if (!iv_valid_ff[kd_ff] && !ffr_vld_ff) begin
                  ffr_vld_in = 1'b1;
                  ffr_in = kd_ff;
               end
            end
            if (state_ff == S_SCAN_LAST) begin
               state_in = S_POOL;
            end else begin
               chk_in = 1'b1;
               kd_in = k_ff;
               if (k_ff == IW'(INTERVALS - 1)) begin
                  state_in = S_SCAN_LAST;
               end else begin
                  k_in = k_ff + IW'(1);
               end
            end
         end
         S_POOL: begin
            ret_en = 1'b1;
            if (rep_ff) begin
               free_en = 1'b1;
               ret_code = frt_pkg::ST_REPEAT;
            end else if (dup_ff) begin
               ret_code = frt_pkg::ST_DUP;
            end else if (!ffr_vld_ff) begin
               free_en = 1'b1;
               ret_code = frt_pkg::ST_POOL;
            end else begin
               ram_we = 1'b1;
               iv_valid_in[ffr_ff] = 1'b1;
               iv_owner_in[ffr_ff] = cur_ff;
               sl_recv_in[cur_ff] = sl_recv_ff[cur_ff] + {4'd0, len_ff};
               ret_code = st_pass_ff;
            end
         end
         S_COMPLETE: begin
            if ((st_ff <= frt_pkg::ST_REPEAT) &&
                (sl_recv_ff[cur_ff] == {1'b0, sl_size_ff[cur_ff]})) begin
               complete_in = 1'b1;
               if (hold_ff != 32'd0) begin
                  sl_arr_in[cur_ff] = now_ff - (timeout_ff - hold_ff);
                  sl_recv_in[cur_ff] = '0;
               end else begin
                  free_en = 1'b1;
               end
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {5'd0, expired_ff, evicted_ff, complete_ff, 2'(slot_ff),
                              st_ff};
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (ret_en) begin
         if (!pass2_ff && (ret_code == frt_pkg::ST_REPEAT)) begin
            pass2_in = 1'b1;
            idx_in = '0;
            state_in = S_SWEEP;
         end else begin
            st_in = (pass2_ff && (ret_code <= frt_pkg::ST_ADDED)) ?
                    frt_pkg::ST_REPEAT : ret_code;
            state_in = S_COMPLETE;
         end
      end

      if (free_en || clr_en) begin
         iv_valid_in = iv_valid_in & ~own_mask;
      end
      if (free_en) begin
         sl_size_in[free_sel] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         timeout_ff <= frt_pkg::TIMEOUT_RESET;
         hold_ff <= frt_pkg::HOLD_RESET;
         no_ov_ff <= 1'b0;
         for (int s = 0; s < SLOTS; s++) begin
            sl_size_ff[s] <= '0;
            sl_arr_ff[s] <= '0;
            sl_recv_ff[s] <= '0;
         end
         iv_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
         pass2_ff <= 1'b0;
         chk_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         timeout_ff <= timeout_in;
         hold_ff <= hold_in;
         no_ov_ff <= no_ov_in;
         sl_size_ff <= sl_size_in;
         sl_arr_ff <= sl_arr_in;
         sl_recv_ff <= sl_recv_in;
         iv_valid_ff <= iv_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pass2_ff <= pass2_in;
         chk_ff <= chk_in;
      end
      func_ff <= func_in;
      src_ff <= src_in;
      dst_ff <= dst_in;
      lens_ff <= lens_in;
      size_ff <= size_in;
      off_ff <= off_in;
      last_ff <= last_in;
      tag_ff <= tag_in;
      len_ff <= len_in;
      now_ff <= now_in;
      sl_tag_ff <= sl_tag_in;
      sl_src_ff <= sl_src_in;
      sl_dst_ff <= sl_dst_in;
      sl_lens_ff <= sl_lens_in;
      iv_owner_ff <= iv_owner_in;
      idx_ff <= idx_in;
      found_ff <= found_in;
      free_ff <= free_in;
      old_ff <= old_in;
      cur_ff <= cur_in;
      slot_ff <= slot_in;
      found_vld_ff <= found_vld_in;
      free_vld_ff <= free_vld_in;
      old_vld_ff <= old_vld_in;
      st_pass_ff <= st_pass_in;
      st_ff <= st_in;
      evicted_ff <= evicted_in;
      complete_ff <= complete_in;
      expired_ff <= expired_in;
      k_ff <= k_in;
      kd_ff <= kd_in;
      ffr_ff <= ffr_in;
      rep_ff <= rep_in;
      dup_ff <= dup_in;
      ffr_vld_ff <= ffr_vld_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// File: sv/frt_checker.sv
module frt_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [frt_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // A waiting response transaction holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // The block stops accepting requests once it has taken one.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[3:0] <= frt_pkg::ST_SWEEP)
      else $error("status code out of range");

   a_sweep: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3:0] == frt_pkg::ST_SWEEP |->
      rsp_tdata[7:4] == 4'd0)
      else $error("sweep response reports a slot");

   a_complete: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[6] |-> rsp_tdata[3:0] <= frt_pkg::ST_REPEAT)
      else $error("completion with a failing status");

endmodule

bind fragment_reassembly_tracker frt_checker u_frt_checker (.*);

// File: bench/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_SLOTS  = 4;
   localparam int NUM_IVS    = 64;
   localparam int NUM_FLOWS  = 5;
   localparam int STALL_LIMIT = 5000;
   localparam int RANDOM_PER_PHASE = 180;

   localparam logic [31:0] PHASE_TIMEOUT [6] = '{32'd3000000, 32'd60, 32'hFFFF_FFFF, 32'd0,
                                                32'd200, 32'd500};
   localparam logic [31:0] PHASE_HOLD [6] = '{32'd250, 32'd20, 32'd0, 32'hFFFF_FFFF, 32'd0,
                                             32'd100};
   localparam logic PHASE_NO_OVR [6] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};

   typedef struct {
      logic        func;
      logic [63:0] src;
      logic [3:0]  src_len;
      logic [63:0] dst;
      logic [3:0]  dst_len;
      logic [10:0] size;
      logic [15:0] tag;
      logic [10:0] off;
      logic [7:0]  len;
      logic [31:0] now;
   } frag_item_type;

   typedef struct {
      logic [3:0] status;
      logic [1:0] slot;
      logic       complete;
      logic       evicted;
      logic [2:0] expired;
   } outcome_type;

   function automatic logic [63:0] byte_mask(logic [3:0] len);
      if (len >= 4'd8) begin
         return '1;
      end
      return (64'd1 << (8 * len)) - 64'd1;
   endfunction

   class reassembly_scoreboard;
      logic [31:0] timeout_ticks = frt_pkg::TIMEOUT_RESET;
      logic [31:0] hold_ticks = frt_pkg::HOLD_RESET;
      logic        no_override = 1'b0;
      logic [10:0] slot_size[NUM_SLOTS];
      logic [15:0] slot_tag[NUM_SLOTS];
      logic [63:0] slot_src[NUM_SLOTS];
      logic [63:0] slot_dst[NUM_SLOTS];
      logic [7:0]  slot_lens[NUM_SLOTS];
      logic [31:0] slot_arrival[NUM_SLOTS];
      logic [11:0] slot_received[NUM_SLOTS];
      bit          iv_valid[NUM_IVS];
      int unsigned iv_owner[NUM_IVS];
      int unsigned iv_start[NUM_IVS];
      int unsigned iv_end[NUM_IVS];
      outcome_type expected_outcomes[$];
      int          mismatches = 0;

      function new();
         foreach (slot_size[s]) begin
            slot_size[s] = '0;
            slot_tag[s] = '0;
            slot_src[s] = '0;
            slot_dst[s] = '0;
            slot_lens[s] = '0;
            slot_arrival[s] = '0;
            slot_received[s] = '0;
         end
         foreach (iv_valid[k]) begin
            iv_valid[k] = 1'b0;
         end
      endfunction

      function void drop_slot(int s);
         foreach (iv_valid[k]) begin
            if (iv_valid[k] && iv_owner[k] == s) begin
               iv_valid[k] = 1'b0;
            end
         end
         slot_size[s] = '0;
      endfunction

      function int unsigned expire_slots(logic [31:0] now);
         int unsigned n;
         logic [31:0] age;
         n = 0;
         for (int s = 0; s < NUM_SLOTS; s++) begin
            age = now - slot_arrival[s];
            if (slot_size[s] != 0 && age > timeout_ticks) begin
               drop_slot(s);
               n++;
            end
         end
         return n;
      endfunction

      // One pass of fragment handling; an overlap restart calls it twice.
      function logic [3:0] place_fragment(frag_item_type it, inout int unsigned slot,
                                          inout bit evicted, inout int unsigned expired);
         logic [63:0] src, dst;
         logic [7:0]  lens;
         logic [31:0] d;
         int          found, free_s, oldest, s, k;
         int unsigned off, len, last;
         bit          restart, dup;
         logic [3:0]  st;
         src = it.src & byte_mask(it.src_len);
         dst = it.dst & byte_mask(it.dst_len);
         lens = {it.dst_len, it.src_len};
         off = {21'd0, it.off};
         len = {24'd0, it.len};
         found = -1;
         free_s = -1;
         oldest = -1;
         restart = 0;
         dup = 0;
         st = frt_pkg::ST_ADDED;
         expired += expire_slots(it.now);
         for (s = 0; s < NUM_SLOTS; s++) begin
            if (slot_size[s] != 0 && slot_size[s] == it.size && slot_tag[s] == it.tag &&
                slot_lens[s] == lens && slot_src[s] == src && slot_dst[s] == dst) begin
               found = s;
               break;
            end
            if (free_s < 0 && slot_size[s] == 0) free_s = s;
            if (oldest < 0) begin
               oldest = s;
            end else begin
               d = slot_arrival[oldest] - slot_arrival[s];
               if (d < frt_pkg::HALF_RANGE) oldest = s;
            end
         end
         if (found >= 0) begin
            s = found;
            slot = s;
            if (hold_ticks != 0 && slot_received[s] == 0) return frt_pkg::ST_CLOSING;
            slot_arrival[s] = it.now;
         end else begin
            if (free_s < 0) begin
               d = it.now - slot_arrival[oldest];
               if (!no_override || d > timeout_ticks) begin
                  drop_slot(oldest);
                  evicted = 1;
                  free_s = oldest;
               end else begin
                  slot = 0;
                  return frt_pkg::ST_FULL;
               end
            end
            s = free_s;
            slot = s;
            slot_size[s] = it.size;
            slot_arrival[s] = it.now;
            slot_src[s] = src;
            slot_dst[s] = dst;
            slot_lens[s] = lens;
            slot_tag[s] = it.tag;
            slot_received[s] = '0;
            st = frt_pkg::ST_NEW;
         end
         if (len == 0 || off + len > slot_size[s]) begin
            drop_slot(s);
            return frt_pkg::ST_BIG;
         end
         last = off + len - 1;
         for (k = 0; k < NUM_IVS; k++) begin
            if (iv_valid[k] && iv_owner[k] == s) begin
               if (iv_start[k] <= last && off <= iv_end[k] &&
                   !(iv_start[k] == off && iv_end[k] == last)) begin
                  restart = 1;
               end else if (iv_start[k] == off) begin
                  dup = 1;
               end
            end
         end
         if (restart) begin
            drop_slot(s);
            return frt_pkg::ST_REPEAT;
         end
         if (dup) return frt_pkg::ST_DUP;
         for (k = 0; k < NUM_IVS; k++) begin
            if (!iv_valid[k]) break;
         end
         if (k >= NUM_IVS) begin
            drop_slot(s);
            return frt_pkg::ST_POOL;
         end
         iv_valid[k] = 1'b1;
         iv_owner[k] = s;
         iv_start[k] = off;
         iv_end[k] = last;
         slot_received[s] = 12'(slot_received[s] + len);
         return st;
      endfunction

      function void note_fragment(frag_item_type it);
         outcome_type o;
         int unsigned slot, expired;
         bit          evicted;
         logic [3:0]  st, again;
         slot = 0;
         expired = 0;
         evicted = 0;
         o.complete = 1'b0;
         if (it.func) begin
            expired = expire_slots(it.now);
            st = frt_pkg::ST_SWEEP;
         end else begin
            st = place_fragment(it, slot, evicted, expired);
            if (st == frt_pkg::ST_REPEAT) begin
               again = place_fragment(it, slot, evicted, expired);
               st = (again <= frt_pkg::ST_ADDED) ? frt_pkg::ST_REPEAT : again;
            end
            if (st <= frt_pkg::ST_REPEAT && slot_received[slot] == slot_size[slot]) begin
               o.complete = 1'b1;
               if (hold_ticks != 0) begin
                  slot_arrival[slot] = it.now - (timeout_ticks - hold_ticks);
                  slot_received[slot] = '0;
               end else begin
                  drop_slot(slot);
               end
            end
         end
         o.status = st;
         o.slot = slot[1:0];
         o.evicted = evicted;
         o.expired = (expired > 7) ? 3'd7 : expired[2:0];
         expected_outcomes.push_back(o);
      endfunction

      function void check_result(logic [frt_pkg::RSP_DATA_W-1:0] d);
         outcome_type o;
         if (expected_outcomes.size() == 0) begin
            $error("unexpected response transaction %h", d);
            mismatches++;
            return;
         end
         o = expected_outcomes.pop_front();
         if (d[3:0] != o.status) begin
            $error("status: expected %0d, actual %0d", o.status, d[3:0]);
            mismatches++;
         end
         if (d[5:4] != o.slot) begin
            $error("slot: expected %0d, actual %0d", o.slot, d[5:4]);
            mismatches++;
         end
         if (d[6] != o.complete) begin
            $error("complete: expected %0d, actual %0d", o.complete, d[6]);
            mismatches++;
         end
         if (d[7] != o.evicted) begin
            $error("evicted: expected %0d, actual %0d", o.evicted, d[7]);
            mismatches++;
         end
         if (d[10:8] != o.expired) begin
            $error("expired_count: expected %0d, actual %0d", o.expired, d[10:8]);
            mismatches++;
         end
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [frt_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                           req_tuser = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [frt_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           csr_psel = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite = 1'b0;
   logic [3:0]                     csr_paddr = '0;
   logic [31:0]                    csr_pwdata = '0;
   logic [31:0]                    csr_prdata;
   logic                           csr_pready;

   reassembly_scoreboard sb = new();
   int            send_idle = 0;
   int            rsp_idle = 0;
   int            stall_cycles = 0;
   logic [31:0]   t_now = '0;
   frag_item_type flow_q[NUM_FLOWS][$];
   frag_item_type last_sent[NUM_FLOWS];
   bit            have_last[NUM_FLOWS];

   fragment_reassembly_tracker i_dut (.*);

   always #5ns clock = ~clock;

   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      rsp_tready <= ($urandom_range(0, 99) >= rsp_idle);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles == STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   function automatic logic [frt_pkg::REQ_DATA_W-1:0] pack_item(frag_item_type it);
      return {2'b00, it.now, it.len, it.off, it.tag, it.size, it.dst_len, it.dst,
              it.src_len, it.src};
   endfunction

   function automatic frag_item_type make_item(int unsigned func, int unsigned sl,
                                               logic [63:0] sa, int unsigned dl,
                                               logic [63:0] da, int unsigned size,
                                               int unsigned tag, int unsigned off,
                                               int unsigned len, logic [31:0] now);
      frag_item_type it;
      it.func = 1'(func);
      it.src_len = 4'(sl);
      it.src = sa;
      it.dst_len = 4'(dl);
      it.dst = da;
      it.size = 11'(size);
      it.tag = 16'(tag);
      it.off = 11'(off);
      it.len = 8'(len);
      it.now = now;
      return it;
   endfunction

   task automatic send_item(frag_item_type it);
      while ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= pack_item(it);
      req_tuser <= it.func;
      do @(posedge clock); while (!req_tready);
      sb.note_fragment(it);
   endtask

   task automatic write_reg(logic [1:0] index, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (index == frt_pkg::REG_TIMEOUT) sb.timeout_ticks = value;
      else if (index == frt_pkg::REG_HOLD) sb.hold_ticks = value;
      else sb.no_override = value[0];
   endtask

   // Cuts a fresh datagram into fragments, mostly in order with a few swaps.
   task automatic plan_datagram(int k);
      frag_item_type base, f;
      int unsigned   pos, chunk, r, i, j;
      bit            tiny;
      base.func = 1'b0;
      base.src_len = 4'($urandom_range(0, 8));
      base.src = {$urandom, $urandom} & byte_mask(base.src_len);
      base.dst_len = 4'($urandom_range(0, 8));
      base.dst = {$urandom, $urandom} & byte_mask(base.dst_len);
      r = $urandom_range(0, 99);
      base.size = (r < 80) ? 11'($urandom_range(1, 120)) :
                  (r < 95) ? 11'($urandom_range(121, 600)) : 11'($urandom_range(601, 2047));
      base.tag = 16'($urandom);
      tiny = base.size <= 120 && $urandom_range(0, 99) < 30;
      pos = 0;
      while (pos < base.size) begin
         chunk = tiny ? $urandom_range(1, 4) : $urandom_range(1, 255);
         if (chunk > base.size - pos) chunk = base.size - pos;
         f = base;
         f.off = 11'(pos);
         f.len = 8'(chunk);
         flow_q[k].push_back(f);
         pos += chunk;
      end
      for (i = 0; i < flow_q[k].size(); i++) begin
         if ($urandom_range(0, 99) < 20) begin
            j = $urandom_range(0, flow_q[k].size() - 1);
            f = flow_q[k][i];
            flow_q[k][i] = flow_q[k][j];
            flow_q[k][j] = f;
         end
      end
      have_last[k] = 0;
   endtask

   task automatic next_random_item(output frag_item_type it);
      int unsigned k, r;
      k = $urandom_range(0, NUM_FLOWS - 1);
      if (flow_q[k].size() == 0) plan_datagram(k);
      r = $urandom_range(0, 99);
      if (r < 4) begin
         it = flow_q[k][0];
         it.off = 11'($urandom_range(0, it.size));
         it.len = 8'($urandom_range(1, 255));
      end else if (r < 8 && have_last[k]) begin
         it = last_sent[k];
      end else if (r < 10) begin
         it = make_item(1, $urandom, {$urandom, $urandom}, $urandom, {$urandom, $urandom},
                        $urandom, $urandom, $urandom, $urandom, 0);
      end else if (r < 13) begin
         it = make_item(0, $urandom_range(0, 8), {$urandom, $urandom},
                        $urandom_range(0, 8), {$urandom, $urandom}, $urandom, $urandom,
                        $urandom, $urandom_range(1, 255), 0);
      end else begin
         it = flow_q[k].pop_front();
         last_sent[k] = it;
         have_last[k] = 1;
      end
      r = $urandom_range(0, 99);
      if (r < 2) t_now = t_now + $urandom;
      else if (r < 8) t_now = t_now + $urandom_range(0, 300);
      else t_now = t_now + $urandom_range(0, 8);
      it.now = t_now;
   endtask

   initial begin
      frag_item_type directed[$];
      frag_item_type it;

      directed.push_back(make_item(1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_item(0, 8, '1, 8, '1, 0, 65535, 0, 1, 1));
      directed.push_back(make_item(0, 1, 64'h12, 1, 64'h34, 10, 3, 0, 0, 2));
      directed.push_back(make_item(0, 8, '1, 0, 0, 2047, 65535, 2047, 255, 3));
      directed.push_back(make_item(0, 0, 0, 8, '1, 255, 9, 0, 255, 4));
      directed.push_back(make_item(0, 0, 0, 8, '1, 255, 9, 0, 255, 5));
      directed.push_back(make_item(0, 2, 64'hBEEF, 2, 64'hCAFE, 20, 1, 0, 10, 6));
      directed.push_back(make_item(0, 2, 64'hBEEF, 2, 64'hCAFE, 20, 1, 0, 10, 7));
      // Partial overlap: the datagram restarts with only the new interval.
      directed.push_back(make_item(0, 2, 64'hBEEF, 2, 64'hCAFE, 20, 1, 5, 10, 8));
      directed.push_back(make_item(0, 2, 64'hBEEF, 2, 64'hCAFE, 20, 1, 15, 5, 9));
      directed.push_back(make_item(0, 2, 64'hBEEF, 2, 64'hCAFE, 20, 1, 0, 5, 10));
      for (int i = 0; i < 5; i++) begin
         directed.push_back(make_item(0, 4, 64'h1000 + i, 4, 64'h2000, 100, 64 + i,
                                      0, 10, 11 + i));
      end
      // Address length above eight bytes still matches on the raw length.
      directed.push_back(make_item(0, 15, '1, 12, '1, 50, 7, 0, 10, 20));
      directed.push_back(make_item(0, 15, '1, 12, '1, 50, 7, 10, 40, 21));
      directed.push_back(make_item(1, 0, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
      directed.push_back(make_item(0, 8, 0, 8, 0, 2047, 0, 1792, 255, 32'hFFFF_FFFF));
      t_now = 32'hFFFF_FFFF;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int p = 0; p < 6; p++) begin
         if (p > 0) begin
            req_tvalid <= 1'b0;
            while (sb.expected_outcomes.size() != 0) @(posedge clock);
            @(posedge clock);
            write_reg(frt_pkg::REG_TIMEOUT, PHASE_TIMEOUT[p]);
            write_reg(frt_pkg::REG_HOLD, PHASE_HOLD[p]);
            write_reg(frt_pkg::REG_NO_OVERR, {31'd0, PHASE_NO_OVR[p]});
         end
         send_idle = (p % 3 == 0) ? 34 : (p % 3 == 1) ? 70 : 0;
         rsp_idle = (p % 3 == 0) ? 70 : (p % 3 == 1) ? 34 : 0;
         if (p == 0) begin
            foreach (directed[i]) send_item(directed[i]);
         end
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            next_random_item(it);
            send_item(it);
         end
      end
      req_tvalid <= 1'b0;
      while (sb.expected_outcomes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// File: files.f
sv/frt_pkg.sv
sv/frt_ram.sv
sv/fragment_reassembly_tracker.sv
sv/frt_checker.sv
bench/tb_top.sv
